[hw/rtl/sacg_pkg.sv]
// Shared types and constants of the steering actuator frame gateway.
// No dependencies; imported by every module of the block.
package sacg_pkg;

  // Configuration port geometry
  localparam int unsigned CFG_AW = 5;
  localparam int unsigned CFG_DW = 32;

  // Received frame identifiers
  localparam logic [28:0] ID_FEEDBACK = 29'h1C2;
  localparam logic [28:0] ID_EPS      = 29'h1C4;
  localparam logic [28:0] ID_SWITCH   = 29'h202;

  // Sent frame identifiers
  localparam logic [10:0] ID_STEER_OUT = 11'h100;
  localparam logic [10:0] ID_LONG_OUT  = 11'h500;

  // Encoding offsets and limits
  localparam logic [15:0]        ZERO_OFFSET  = 16'd12480;
  localparam logic [13:0]        ACCEL_OFFSET = 14'd1444;
  localparam logic signed [12:0] ACCEL_FLOOR  = -13'sd1400;
  localparam logic [1:0]         EPS_READY    = 2'd2;

  // Frame payload codes
  localparam logic [7:0] LAT_FLAGS    = 8'h14;
  localparam logic [7:0] MODE_ACCEL   = 8'h07;
  localparam logic [7:0] MODE_DECEL   = 8'h06;
  localparam logic [3:0] DECEL_FLAG   = 4'h4;

  // Register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_STEP_LIMIT   = 3'd0,
    REG_DEAD_BAND    = 3'd1,
    REG_ANGLE_LIMIT  = 3'd2,
    REG_HS_TICKS     = 3'd3,
    REG_TORQUE_LIMIT = 3'd4
  } reg_idx_e;

  // Steering request handshake
  typedef enum logic [1:0] {
    HS_OFF     = 2'd0,
    HS_PENDING = 2'd1,
    HS_ACTIVE  = 2'd2
  } hs_state_e;

  typedef struct packed {
    logic [9:0]  step_limit;
    logic [7:0]  dead_band;
    logic [13:0] angle_limit;
    logic [3:0]  hs_ticks;
    logic [14:0] torque_limit;
  } cfg_t;

  // One tick job from front to back
  typedef struct packed {
    hs_state_e          hs_state;
    logic               lat_en;
    logic [1:0]         shift;
    logic signed [14:0] steer_cmd;
    logic               has_long;
    logic signed [15:0] torque;
    logic signed [12:0] accel;
  } job_t;

  // Back-end status for checking
  typedef struct packed {
    logic long_pend;
    logic out_valid;
  } bk_stat_t;

endpackage

[hw/rtl/sacg_regs.sv]
// Configuration register file on an APB-style port.
// Depends on sacg_pkg.
module sacg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sacg_pkg::CFG_AW-1:0] paddr,
  input  logic [sacg_pkg::CFG_DW-1:0] pwdata,
  output logic [sacg_pkg::CFG_DW-1:0] prdata,
  output logic                        pready,
  output sacg_pkg::cfg_t              cfg_o
);
  import sacg_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.step_limit   <= 10'd192;
      cfg_q.dead_band    <= 8'd32;
      cfg_q.angle_limit  <= 14'd8000;
      cfg_q.hs_ticks     <= 4'd11;
      cfg_q.torque_limit <= 15'd10000;
    end else if (wr_en) begin
      unique case (idx)
        REG_STEP_LIMIT:   cfg_q.step_limit   <= pwdata[9:0];
        REG_DEAD_BAND:    cfg_q.dead_band    <= pwdata[7:0];
        REG_ANGLE_LIMIT:  cfg_q.angle_limit  <= pwdata[13:0];
        REG_HS_TICKS:     cfg_q.hs_ticks     <= pwdata[3:0];
        REG_TORQUE_LIMIT: cfg_q.torque_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_STEP_LIMIT:   prdata = CFG_DW'(cfg_q.step_limit);
      REG_DEAD_BAND:    prdata = CFG_DW'(cfg_q.dead_band);
      REG_ANGLE_LIMIT:  prdata = CFG_DW'(cfg_q.angle_limit);
      REG_HS_TICKS:     prdata = CFG_DW'(cfg_q.hs_ticks);
      REG_TORQUE_LIMIT: prdata = CFG_DW'(cfg_q.torque_limit);
      default:          prdata = '0;
    endcase
  end

endmodule

[hw/rtl/sacg_front.sv]
// Front end: decodes received frames into vehicle state, steps the handshake
// and the rate-limited steering command on each tick. Depends on sacg_pkg.
module sacg_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic                func_i,
  input  logic [28:0]         frame_id_i,
  input  logic [63:0]         frame_data_i,
  input  logic signed [14:0]  target_angle_i,
  input  logic [1:0]          shift_request_i,
  input  logic signed [15:0]  target_torque_i,
  input  logic signed [12:0]  target_accel_i,
  input  sacg_pkg::cfg_t      cfg_i,
  output logic                job_push_o,
  output sacg_pkg::job_t      job_o
);
  import sacg_pkg::*;

  // Vehicle state
  logic               lat_en_q;
  logic [2:0]         long_mode_q;
  logic [1:0]         eps_q;
  logic [15:0]        fb_q;
  logic signed [14:0] cmd_q, cmd_d;
  hs_state_e          hs_q, hs_d;
  logic [3:0]         hs_cnt_q, hs_cnt_d;

  logic               is_tick;
  logic [4:0]         cnt_inc;
  logic signed [16:0] tgt, cmd_ext, step_s, db_s, err_raw, err_clip, err_db, sum;
  logic signed [17:0] pre, lim;

  assign is_tick = accept_i && func_i;

  // Handshake step
  always_comb begin
    hs_d     = hs_q;
    hs_cnt_d = hs_cnt_q;
    cnt_inc  = {1'b0, hs_cnt_q} + 5'd1;
    if (lat_en_q) begin
      if (hs_q != HS_ACTIVE) begin
        if (cnt_inc > {1'b0, cfg_i.hs_ticks}) begin
          hs_d     = HS_ACTIVE;
          hs_cnt_d = '0;
        end else begin
          hs_d     = HS_PENDING;
          hs_cnt_d = cnt_inc[3:0];
        end
      end
    end else begin
      hs_d = HS_OFF;
    end
  end

  // Steer command: step clamp, dead band, snap, or feedback; angle clamp
  always_comb begin
    tgt      = 17'(target_angle_i);
    cmd_ext  = 17'(cmd_q);
    step_s   = $signed({7'b0, cfg_i.step_limit});
    db_s     = $signed({9'b0, cfg_i.dead_band});
    err_raw  = tgt - cmd_ext;
    err_clip = err_raw;
    if (err_raw > step_s) begin
      err_clip = step_s;
    end else if (err_raw < -step_s) begin
      err_clip = -step_s;
    end
    err_db = err_clip;
    if (err_clip < db_s && err_clip > -db_s) begin
      err_db = '0;
    end
    sum = cmd_ext + err_db;
    if (!err_db[16] && sum > tgt) begin
      sum = tgt;
    end else if (err_db[16] && sum < tgt) begin
      sum = tgt;
    end
    if (eps_q == EPS_READY) begin
      pre = 18'(sum);
    end else begin
      pre = $signed({2'b0, fb_q}) - $signed({2'b0, ZERO_OFFSET});
    end
    lim = $signed({4'b0, cfg_i.angle_limit});
    priority if (pre > lim) begin
      cmd_d = lim[14:0];
    end else if (pre < -lim) begin
      cmd_d = 15'(-lim);
    end else begin
      cmd_d = pre[14:0];
    end
  end

  // State update
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_en_q    <= 1'b0;
      long_mode_q <= '0;
      eps_q       <= '0;
      fb_q        <= ZERO_OFFSET;
      cmd_q       <= '0;
      hs_q        <= HS_OFF;
      hs_cnt_q    <= '0;
    end else if (accept_i) begin
      if (func_i) begin
        hs_q     <= hs_d;
        hs_cnt_q <= hs_cnt_d;
        cmd_q    <= cmd_d;
      end else begin
        priority if (frame_id_i == ID_FEEDBACK) begin
          fb_q <= frame_data_i[47:32];
        end else if (frame_id_i == ID_EPS) begin
          eps_q <= frame_data_i[30:29];
        end else if (frame_id_i == ID_SWITCH) begin
          lat_en_q    <= frame_data_i[17];
          long_mode_q <= frame_data_i[10:8];
        end else begin
        end
      end
    end
  end

  // Tick job toward the back end
  assign job_push_o     = is_tick;
  assign job_o.hs_state  = hs_d;
  assign job_o.lat_en    = lat_en_q;
  assign job_o.shift     = shift_request_i;
  assign job_o.steer_cmd = cmd_d;
  assign job_o.has_long  = (long_mode_q != 3'd0);
  assign job_o.torque    = target_torque_i;
  assign job_o.accel     = target_accel_i;

endmodule

[hw/rtl/sacg_fifo.sv]
// Short job queue between front and back ends.
// Depends on sacg_pkg for the job type.
module sacg_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sacg_pkg::job_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output sacg_pkg::job_t data_o
);
  import sacg_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  job_t          mem_q [DEPTH];
  logic [AW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == LAST) ? '0 : wr_q + AW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == LAST) ? '0 : rd_q + AW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

[hw/rtl/sacg_back.sv]
// Back end: turns tick jobs into the steering frame and, when enabled, the
// torque/deceleration frame, held in an output register. Depends on sacg_pkg.
module sacg_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_empty_i,
  input  sacg_pkg::job_t     job_i,
  output logic               job_pop_o,
  input  logic [14:0]        torque_limit_i,
  input  logic               pop_i,
  output logic               empty_o,
  output logic [10:0]        out_id_o,
  output logic [63:0]        out_data_o,
  output logic               last_o,
  output sacg_pkg::bk_stat_t stat_o
);
  import sacg_pkg::*;

  logic               valid_q;
  logic               long_pend_q;
  logic [10:0]        id_q;
  logic [63:0]        data_q;
  logic               last_q;
  logic signed [15:0] trq_q;
  logic signed [12:0] acc_q;

  logic               slot_free;
  logic               decel;
  logic signed [15:0] trq_c;
  logic signed [12:0] acc_c;
  logic [13:0]        raw14;
  logic [11:0]        raw;
  logic [15:0]        enc;
  logic [7:0]         b2;
  logic [63:0]        steer_data, long_data;

  assign slot_free = !valid_q || pop_i;
  assign job_pop_o = slot_free && !long_pend_q && !job_empty_i;

  // Steering frame payload
  always_comb begin
    enc        = 16'(job_i.steer_cmd) + ZERO_OFFSET;
    b2         = {job_i.shift, 6'b0} | (job_i.lat_en ? LAT_FLAGS : 8'h00);
    steer_data = {16'b0, b2, 6'b0, job_i.hs_state, enc, 16'b0};
  end

  // Longitudinal frame payload from the held job
  always_comb begin
    decel = acc_q[12];
    trq_c = trq_q;
    acc_c = acc_q;
    if (!decel) begin
      if (trq_q > $signed({1'b0, torque_limit_i})) begin
        trq_c = $signed({1'b0, torque_limit_i});
      end
    end else if (acc_q < ACCEL_FLOOR) begin
      acc_c = ACCEL_FLOOR;
    end
    raw14     = 14'(acc_c) + ACCEL_OFFSET;
    raw       = (raw14 > 14'd4095) ? 12'hFFF : raw14[11:0];
    long_data = {24'b0, (decel ? MODE_DECEL : MODE_ACCEL),
                 ~trq_c[15], trq_c[14:0],
                 raw[11:4], raw[3:0], (decel ? DECEL_FLAG : 4'h0)};
  end

  // Output register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      long_pend_q <= 1'b0;
    end else if (slot_free) begin
      if (long_pend_q) begin
        valid_q     <= 1'b1;
        long_pend_q <= 1'b0;
      end else if (!job_empty_i) begin
        valid_q     <= 1'b1;
        long_pend_q <= job_i.has_long;
      end else begin
        valid_q <= 1'b0;
      end
    end
  end

  // Output and held payload
  always_ff @(posedge clk_i) begin
    if (slot_free) begin
      if (long_pend_q) begin
        id_q   <= ID_LONG_OUT;
        data_q <= long_data;
        last_q <= 1'b1;
      end else if (!job_empty_i) begin
        id_q   <= ID_STEER_OUT;
        data_q <= steer_data;
        last_q <= !job_i.has_long;
        trq_q  <= job_i.torque;
        acc_q  <= job_i.accel;
      end
    end
  end

  assign empty_o          = !valid_q;
  assign out_id_o         = id_q;
  assign out_data_o       = data_q;
  assign last_o           = last_q;
  assign stat_o.long_pend = long_pend_q;
  assign stat_o.out_valid = valid_q;

endmodule

[hw/rtl/steering_actuator_frame_gateway.sv]
// Top level of the steering actuator frame gateway: register file, front end,
// job queue and back end. Depends on sacg_pkg, sacg_regs, sacg_front,
// sacg_fifo and sacg_back.
//
//   channel | handshake            | payload
//   --------+----------------------+------------------------------------------
//   input   | push / full          | func, frame_id, frame_data, targets
//   result  | pop / empty          | out_id, out_data, last_of_tick
//   config  | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// An item is taken every cycle while the job queue has room; frame items
// finish in the front end at acceptance and give no result. A tick leaves the
// steering frame and, with a longitudinal mode set, the torque frame, issued one
// per cycle from the back end's output register while the result side pops.
// The steering frame goes through the job queue, then the output register. Reset is
// asynchronous, active low; a stalled result side fills the queue, then full rises.
module steering_actuator_frame_gateway #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input queue side
  input  logic                        push,
  output logic                        full,
  input  logic                        func_i,
  input  logic [28:0]                 frame_id_i,
  input  logic [63:0]                 frame_data_i,
  input  logic signed [14:0]          target_angle_i,
  input  logic [1:0]                  shift_request_i,
  input  logic signed [15:0]          target_torque_i,
  input  logic signed [12:0]          target_accel_i,
  // result queue side
  output logic                        empty,
  input  logic                        pop,
  output logic [10:0]                 out_id_o,
  output logic [63:0]                 out_data_o,
  output logic                        last_of_tick_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sacg_pkg::CFG_AW-1:0] paddr,
  input  logic [sacg_pkg::CFG_DW-1:0] pwdata,
  output logic [sacg_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import sacg_pkg::*;

  cfg_t     cfg;
  job_t     job_in, job_out;
  logic     accept, job_push, job_pop, q_full, q_empty;
  bk_stat_t bk_stat;

  assign full   = q_full;
  assign accept = push && !q_full;

  sacg_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  sacg_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .func_i          (func_i),
    .frame_id_i      (frame_id_i),
    .frame_data_i    (frame_data_i),
    .target_angle_i  (target_angle_i),
    .shift_request_i (shift_request_i),
    .target_torque_i (target_torque_i),
    .target_accel_i  (target_accel_i),
    .cfg_i           (cfg),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  sacg_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  sacg_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_empty_i    (q_empty),
    .job_i          (job_out),
    .job_pop_o      (job_pop),
    .torque_limit_i (cfg.torque_limit),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_id_o       (out_id_o),
    .out_data_o     (out_data_o),
    .last_o         (last_of_tick_o),
    .stat_o         (bk_stat)
  );

`ifndef SYNTH
  // A pending longitudinal frame always sits behind a shown steering frame
  a_pend_behind_steer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bk_stat.long_pend |-> (bk_stat.out_valid && out_id_o == ID_STEER_OUT &&
                           !last_of_tick_o))
    else $error("longitudinal frame pending without steering frame shown");

  // Only the two known frames leave the block
  a_known_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (out_id_o == ID_STEER_OUT || out_id_o == ID_LONG_OUT))
    else $error("unknown frame identifier on result");

  // The longitudinal frame always closes its tick
  a_long_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_id_o == ID_LONG_OUT) |-> last_of_tick_o)
    else $error("longitudinal frame not marked last");

  // A transfer of a steering frame with a follower shows the follower next
  a_long_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !empty && bk_stat.long_pend) |=> (!empty && out_id_o == ID_LONG_OUT))
    else $error("longitudinal frame did not follow steering frame");
`endif

endmodule

[sim/tb_steering_actuator_frame_gateway.sv]
`timescale 1ns / 1ps

// Testbench for steering_actuator_frame_gateway: directed cases, register sweeps, random
// traffic with idling on both queue sides and a long result stall, all checked per field.
// Depends on sacg_pkg and the gateway RTL; reads no files.
module tb_steering_actuator_frame_gateway;
  import sacg_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 150;

  typedef struct {
    logic [10:0] id;
    logic [63:0] data;
    logic        last;
  } can_frame_t;

  // DUT signals
  logic               clk           = 1'b0;
  logic               rst_n         = 1'b0;
  logic               push          = 1'b0;
  logic               full;
  logic               func          = 1'b0;
  logic [28:0]        frame_id      = '0;
  logic [63:0]        frame_data    = '0;
  logic signed [14:0] target_angle  = '0;
  logic [1:0]         shift_request = '0;
  logic signed [15:0] target_torque = '0;
  logic signed [12:0] target_accel  = '0;
  logic               empty;
  logic               pop           = 1'b0;
  logic [10:0]        out_id;
  logic [63:0]        out_data;
  logic               last_of_tick;
  logic               psel          = 1'b0;
  logic               penable       = 1'b0;
  logic               pwrite        = 1'b0;
  logic [CFG_AW-1:0]  paddr         = '0;
  logic [CFG_DW-1:0]  pwdata        = '0;
  logic [CFG_DW-1:0]  prdata;
  logic               pready;

  int errors        = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;

  // Local copy of the gateway registers and vehicle state
  cfg_t       cfg_q = '{step_limit: 10'd192, dead_band: 8'd32, angle_limit: 14'd8000,
                        hs_ticks: 4'd11, torque_limit: 15'd10000};
  logic       lat_en_q    = 1'b0;
  logic [2:0] long_mode_q = 3'd0;
  logic [1:0] eps_q       = 2'd0;
  logic [15:0] feedback_q = ZERO_OFFSET;
  int         steer_cmd_q = 0;
  hs_state_e  hs_state_q  = HS_OFF;
  logic [3:0] hs_count_q  = 4'd0;
  can_frame_t expected_frames[$];

  always #HALF_PERIOD clk = ~clk;

  steering_actuator_frame_gateway uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push            (push),
    .full            (full),
    .func_i          (func),
    .frame_id_i      (frame_id),
    .frame_data_i    (frame_data),
    .target_angle_i  (target_angle),
    .shift_request_i (shift_request),
    .target_torque_i (target_torque),
    .target_accel_i  (target_accel),
    .empty           (empty),
    .pop             (pop),
    .out_id_o        (out_id),
    .out_data_o      (out_data),
    .last_of_tick_o  (last_of_tick),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  // Frame bookkeeping and tick processing: updates state, queues the frames a tick sends
  function automatic void predict_frames(input logic f, input logic [28:0] id,
                                         input logic [63:0] d,
                                         input logic signed [14:0] ang,
                                         input logic [1:0] sh,
                                         input logic signed [15:0] tq,
                                         input logic signed [12:0] acc);
    int         nxt, target, err, step, band, lim, enc, tqi, acci, raw;
    logic       decel;
    logic [7:0] b2, b3;
    can_frame_t fr;
    if (!f) begin
      if (id == ID_FEEDBACK) begin
        feedback_q = d[47:32];
      end else if (id == ID_EPS) begin
        eps_q = d[30:29];
      end else if (id == ID_SWITCH) begin
        lat_en_q    = d[17];
        long_mode_q = d[10:8];
      end
    end else begin
      // steering request handshake; count is kept while lateral is off
      if (lat_en_q) begin
        if (hs_state_q != HS_ACTIVE) begin
          nxt        = int'(hs_count_q) + 1;
          hs_state_q = HS_PENDING;
          if (nxt > int'(cfg_q.hs_ticks)) begin
            hs_state_q = HS_ACTIVE;
            hs_count_q = 4'd0;
          end else begin
            hs_count_q = nxt[3:0];
          end
        end
      end else begin
        hs_state_q = HS_OFF;
      end

      // rate limit with dead band and one-sided snap, else follow feedback
      target = int'(ang);
      if (eps_q == EPS_READY) begin
        step = int'(cfg_q.step_limit);
        band = int'(cfg_q.dead_band);
        err  = target - steer_cmd_q;
        if (err > step) err = step;
        if (err < -step) err = -step;
        if (err < band && err > -band) err = 0;
        steer_cmd_q += err;
        if (err >= 0 && steer_cmd_q > target) steer_cmd_q = target;
        else if (err < 0 && steer_cmd_q < target) steer_cmd_q = target;
      end else begin
        steer_cmd_q = int'(feedback_q) - int'(ZERO_OFFSET);
      end
      lim = int'(cfg_q.angle_limit);
      if (steer_cmd_q > lim) steer_cmd_q = lim;
      else if (steer_cmd_q < -lim) steer_cmd_q = -lim;

      enc     = steer_cmd_q + int'(ZERO_OFFSET);
      b2      = {sh, 6'b0} | (lat_en_q ? LAT_FLAGS : 8'h00);
      b3      = {6'b0, hs_state_q};
      fr.id   = ID_STEER_OUT;
      fr.data = {16'h0, b2, b3, enc[15:0], 16'h0};
      fr.last = (long_mode_q == 3'd0);
      expected_frames.push_back(fr);

      // torque / deceleration frame
      if (long_mode_q != 3'd0) begin
        tqi   = int'(tq);
        acci  = int'(acc);
        decel = (acci < 0);
        if (!decel) begin
          if (tqi > int'(cfg_q.torque_limit)) tqi = int'(cfg_q.torque_limit);
        end else begin
          if (acci < int'(ACCEL_FLOOR)) acci = int'(ACCEL_FLOOR);
        end
        raw = acci + int'(ACCEL_OFFSET);
        if (raw > 4095) raw = 4095;
        tqi     = tqi + 32768;
        b3      = decel ? MODE_DECEL : MODE_ACCEL;
        fr.id   = ID_LONG_OUT;
        fr.data = {24'h0, b3, tqi[15:0], raw[11:4], raw[3:0],
                   (decel ? DECEL_FLAG : 4'h0)};
        fr.last = 1'b1;
        expected_frames.push_back(fr);
      end
    end
  endfunction

  // Result side: random pop, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      pop       <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop       <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compare each popped frame with the oldest expected one
  always @(posedge clk) begin : check_results
    can_frame_t want;
    if (rst_n && pop && !empty) begin
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, got id %h data %h last %b",
                 $time, out_id, out_data, last_of_tick);
      end else begin
        want = expected_frames.pop_front();
        if (out_id !== want.id) begin
          errors++;
          $display("%0t: out_id expected %h got %h", $time, want.id, out_id);
        end
        if (out_data !== want.data) begin
          errors++;
          $display("%0t: out_data expected %h got %h", $time, want.data, out_data);
        end
        if (last_of_tick !== want.last) begin
          errors++;
          $display("%0t: last_of_tick expected %b got %b", $time, want.last, last_of_tick);
        end
      end
    end
  end

  // One input transfer; push stays high afterwards unless the sender idles
  task automatic send_item(input logic f, input logic [28:0] id, input logic [63:0] d,
                           input logic signed [14:0] ang, input logic [1:0] sh,
                           input logic signed [15:0] tq, input logic signed [12:0] acc);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    push          <= 1'b1;
    func          <= f;
    frame_id      <= id;
    frame_data    <= d;
    target_angle  <= ang;
    shift_request <= sh;
    target_torque <= tq;
    target_accel  <= acc;
    do @(posedge clk); while (full);
    predict_frames(f, id, d, ang, sh, tq, acc);
  endtask

  task automatic send_tick(input logic signed [14:0] ang, input logic [1:0] sh,
                           input logic signed [15:0] tq, input logic signed [12:0] acc);
    send_item(1'b1, 29'($urandom), {$urandom, $urandom}, ang, sh, tq, acc);
  endtask

  task automatic send_frame(input logic [28:0] id, input logic [63:0] d);
    send_item(1'b0, id, d, 15'($urandom), 2'($urandom), 16'($urandom), 13'($urandom));
  endtask

  // Drop push, let all expected frames drain, then idle for the drain period
  task automatic wait_idle();
    push <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Back-to-back APB writes keep psel high; the caller closes the burst
  task automatic apb_write(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      REG_STEP_LIMIT:   cfg_q.step_limit   = value[9:0];
      REG_DEAD_BAND:    cfg_q.dead_band    = value[7:0];
      REG_ANGLE_LIMIT:  cfg_q.angle_limit  = value[13:0];
      REG_HS_TICKS:     cfg_q.hs_ticks     = value[3:0];
      REG_TORQUE_LIMIT: cfg_q.torque_limit = value[14:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int step, input int band, input int alim,
                            input int ticks, input int tlim);
    wait_idle();
    apb_write(REG_STEP_LIMIT, step);
    apb_write(REG_DEAD_BAND, band);
    apb_write(REG_ANGLE_LIMIT, alim);
    apb_write(REG_HS_TICKS, ticks);
    apb_write(REG_TORQUE_LIMIT, tlim);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Mostly ticks and the three known frames; a tenth are unknown identifiers
  task automatic send_random_item(output logic counted);
    int                 r, span, band;
    logic [28:0]        id;
    logic [63:0]        d;
    logic signed [14:0] ang;
    logic signed [15:0] tq;
    logic signed [12:0] acc;
    r       = $urandom_range(99);
    d       = {$urandom, $urandom};
    counted = 1'b1;
    if (r < 60) begin
      band = int'(cfg_q.dead_band);
      span = int'(cfg_q.step_limit) + band + 16;
      case ($urandom_range(2))
        0:       ang = 15'($urandom);
        1:       ang = 15'(steer_cmd_q + int'($urandom_range(0, 2 * span)) - span);
        default: ang = 15'(steer_cmd_q + int'($urandom_range(0, 2 * band + 2)) - band - 1);
      endcase
      if ($urandom_range(3) == 0) begin
        tq = 16'(int'(cfg_q.torque_limit) + int'($urandom_range(0, 8)) - 4);
      end else begin
        tq = 16'($urandom);
      end
      case ($urandom_range(2))
        0:       acc = 13'($urandom);
        1:       acc = 13'(int'($urandom_range(0, 20)) - 1410);
        default: acc = 13'(int'($urandom_range(0, 4200)) - 1500);
      endcase
      send_tick(ang, 2'($urandom), tq, acc);
    end else begin
      if (r < 70) begin
        id = ID_FEEDBACK;
        if ($urandom_range(4) != 0) begin
          d[47:32] = 16'(int'(ZERO_OFFSET) + int'($urandom_range(0, 8000)) - 4000);
        end
      end else if (r < 80) begin
        id = ID_EPS;
        if ($urandom_range(3) != 0) d[30:29] = EPS_READY;
      end else if (r < 90) begin
        id     = ID_SWITCH;
        d[17]  = ($urandom_range(4) != 0);
      end else begin
        counted = 1'b0;
        if ($urandom_range(1) != 0) id = 29'($urandom);
        else id = ID_SWITCH ^ (29'd1 << $urandom_range(28));
      end
      send_frame(id, d);
    end
  endtask

  task automatic run_traffic(input int n, input int s_pct, input int r_pct);
    int   done_items;
    logic counted;
    send_idle_pct = s_pct;
    recv_idle_pct <= r_pct;
    done_items    = 0;
    while (done_items < n) begin
      send_random_item(counted);
      if (counted) done_items++;
    end
  endtask

  // Reset values, field extremes, both frame kinds and the steering corner cases
  task automatic test_directed_cases();
    recv_idle_pct <= 30;
    send_tick(15'sd0, 2'd0, 16'sd0, 13'sd0);
    send_frame(29'h1FFF_FFFF, '1);                      // unknown id, ignored
    send_frame(ID_FEEDBACK, 64'h0000_FFFF_0000_0000);   // feedback far positive
    send_tick(15'sh3FFF, 2'd3, 16'sd0, 13'sd0);
    send_frame(ID_FEEDBACK, 64'h0);                     // feedback far negative
    send_tick(-15'sd16384, 2'd1, 16'sd0, 13'sd0);
    send_frame(ID_FEEDBACK, 64'h0000_3124_0000_0000);   // +100 counts
    send_frame(ID_SWITCH, 64'h0000_0000_0002_0000);     // lateral on, no longitudinal
    send_tick(15'sd0, 2'd2, 16'sd0, 13'sd0);
    send_frame(ID_EPS, 64'hFFFF_FFFF_DFFF_FFFF);        // steering ready
    send_frame(ID_SWITCH, '1);                          // lateral on, mode 7
    send_tick(15'sh3FFF, 2'd1, 16'sh7FFF, 13'sd0);      // step clamp up, torque clamp
    send_tick(-15'sd16384, 2'd2, -16'sd32768, -13'sd4096); // step down, accel floor
    send_tick(15'(steer_cmd_q - 10), 2'd0, 16'sd0, 13'sd1);  // inside band below: snap
    send_tick(15'(steer_cmd_q + 10), 2'd0, 16'sd10000, 13'sh0FFF); // band hold, saturate
    send_tick(15'(steer_cmd_q), 2'd3, 16'sd0, -13'sd1);
    send_tick(15'sd0, 2'd0, 16'sd12345, 13'sd2651);
    send_frame(ID_SWITCH, 64'hFFFF_FFFF_FFFD_F8FF);     // lateral off, mode 0
    send_tick(15'sd0, 2'd1, 16'sd0, 13'sd0);
    send_frame(ID_EPS, 64'h0000_0000_2000_0000);        // steering not ready
    send_tick(15'sd500, 2'd0, 16'sd0, 13'sd0);
    send_frame(ID_FEEDBACK | 29'h1000_0000, 64'h0);     // near miss id, ignored
    send_tick(15'sd0, 2'd2, 16'sd0, 13'sd0);
  endtask

  task automatic test_register_sweep();
    set_config(0, 0, 0, 0, 0);
    run_traffic(60, 10, 10);
    set_config(1023, 255, 16383, 15, 32767);
    run_traffic(60, 10, 10);
    repeat (3) begin
      set_config($urandom_range(1023), $urandom_range(255), $urandom_range(16383),
                 $urandom_range(15), $urandom_range(32767));
      run_traffic(60, 10, 10);
    end
    set_config(192, 32, 8000, 11, 10000);
    run_traffic(60, 10, 10);
  endtask

  task automatic test_random_traffic();
    run_traffic(250, 18, 51);
    run_traffic(250, 51, 18);
    run_traffic(250, 0, 0);
  endtask

  // Receiver holds off while ticks with two frames each keep coming
  task automatic test_result_stall();
    send_idle_pct = 0;
    recv_idle_pct <= 0;
    send_frame(ID_SWITCH, 64'h0000_0000_0002_0300);
    send_frame(ID_EPS, 64'h0000_0000_4000_0000);
    hold_req <= hold_req + 1;
    repeat (40) send_tick(15'($urandom), 2'($urandom), 16'($urandom), 13'($urandom));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_register_sweep();
    test_random_traffic();
    test_result_stall();
    wait_idle();
    if (errors == 0) begin
      $display("tb_steering_actuator_frame_gateway OK");
    end else begin
      $display("tb_steering_actuator_frame_gateway NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("tb_steering_actuator_frame_gateway NOT OK");
    $finish;
  end

endmodule

[steering_actuator_frame_gateway.f]
hw/rtl/sacg_pkg.sv
hw/rtl/sacg_regs.sv
hw/rtl/sacg_front.sv
hw/rtl/sacg_fifo.sv
hw/rtl/sacg_back.sv
hw/rtl/steering_actuator_frame_gateway.sv
sim/tb_steering_actuator_frame_gateway.sv
